// ----- hdl/hsvfg_pkg.sv -----
// ----------------------------------------------------------------------------
// hsvfg_pkg
// Shared constants, register codes and pipeline types of the HSV foreground
// mask block.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvfg_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RADIUS = 7;
  localparam int MIN_DIM    = 16;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 6 * MAX_RADIUS + 8) ;
  localparam int DIM_W  = $clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1) ?
                          $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
  localparam int RAD_W  = 3;
  localparam int HIST_W = 2 * MAX_RADIUS;
  localparam int WIN_W  = 2 * MAX_RADIUS + 1;
  localparam int K_W    = $clog2(HIST_W + 1);
  localparam int SUM_W  = COL_W + 2;
  localparam int OUT_W  = 10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam int NUM_STAGES = 3;
  localparam int PIPE_DEPTH = 2 * NUM_STAGES;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUE_THR    = 3'd0,
    REG_SAT_THR    = 3'd1,
    REG_VAL_THR    = 3'd2,
    REG_ERODE_RAD  = 3'd3,
    REG_DILATE_RAD = 3'd4,
    REG_IMG_WIDTH  = 3'd5,
    REG_IMG_HEIGHT = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic             run;
    logic [COL_W-1:0] x;
    logic [K_W-1:0]   k;
    logic             emit;
    logic [WIN_W-1:0] mm;
  } stg_ctl_t;

  typedef struct packed {
    logic             valid;
    stg_ctl_t         ctl2;
    stg_ctl_t         ctl3;
    logic [OUT_W-1:0] col;
    logic [OUT_W-1:0] row;
    logic             last;
  } tag_t;

  typedef struct packed {
    logic             mask;
    logic [OUT_W-1:0] col;
    logic [OUT_W-1:0] row;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/hsvfg_if.sv -----
// ----------------------------------------------------------------------------
// hsvfg interfaces
// Pixel pair input, mask result output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsvfg_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] pixel_hue;
  logic [7:0] pixel_sat;
  logic [7:0] pixel_val;
  logic [7:0] back_hue;
  logic [7:0] back_sat;
  logic [7:0] back_val;
  modport source (output valid, op, pixel_hue, pixel_sat, pixel_val,
                  back_hue, back_sat, back_val, input ready);
  modport sink (input valid, op, pixel_hue, pixel_sat, pixel_val,
                back_hue, back_sat, back_val, output ready);
endinterface

interface hsvfg_out_if;
  logic       valid;
  logic       ready;
  logic       mask;
  logic [9:0] out_col;
  logic [9:0] out_row;
  logic       frame_last;
  modport source (output valid, mask, out_col, out_row, frame_last, input ready);
  modport sink (input valid, mask, out_col, out_row, frame_last, output ready);
endinterface

interface hsvfg_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [hsvfg_pkg::CFG_IDX_W-1:0]     index;
  logic [hsvfg_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/hsvfg_stage.sv -----
// ----------------------------------------------------------------------------
// hsvfg_stage
// One morphology stage: column history memory with read-modify-write,
// vertical reduce, horizontal window shift and masked reduce.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvfg_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                dil_i,
  input  wire logic                valid_i,
  input  wire hsvfg_pkg::stg_ctl_t ctl_i,
  input  wire logic                bin_i,
  output logic                     has_o,
  output logic                     bit_o
);
  import hsvfg_pkg::*;

  logic [HIST_W-1:0] mem [MAX_WIDTH];
  logic [HIST_W-1:0] rd_q;
  logic              a_valid_q;
  stg_ctl_t          a_ctl_q;
  logic              a_bin_q;
  logic [WIN_W-1:0]  win_q, win_d;
  logic [HIST_W-1:0] kmask;
  logic [HIST_W-1:0] wr_data;
  logic [WIN_W-1:0]  sel;
  logic              upd, v, has_d, bit_d, has_q, bit_q;

  always_ff @(posedge clk_i) begin
    if (valid_i && ctl_i.run) begin
      rd_q <= mem[ctl_i.x];
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      mem[a_ctl_q.x] <= wr_data;
    end
  end

  always_comb begin
    upd = a_valid_q && a_ctl_q.run;
    for (int j = 0; j < HIST_W; j++) begin
      kmask[j] = K_W'(j) < a_ctl_q.k;
    end
    if (dil_i) begin
      v = a_bin_q || ((rd_q & kmask) != '0);
    end else begin
      v = a_bin_q && ((rd_q & kmask) == kmask);
    end
    wr_data = {rd_q[HIST_W-2:0], a_bin_q};
    win_d   = upd ? {win_q[WIN_W-2:0], v} : win_q;
    sel     = win_d & a_ctl_q.mm;
    has_d   = upd && a_ctl_q.emit;
    bit_d   = dil_i ? (sel != '0) : (sel == a_ctl_q.mm);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      win_q     <= '0;
      has_q     <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      win_q     <= win_d;
      has_q     <= has_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_ctl_q <= ctl_i;
    a_bin_q <= bin_i;
    bit_q   <= bit_d;
  end

  assign has_o = has_q;
  assign bit_o = bit_q;

endmodule

`default_nettype wire

// ----- hdl/hsv_foreground_mask_with_morphology.sv -----
// ----------------------------------------------------------------------------
// hsv_foreground_mask_with_morphology
// Thresholded HSV difference mask followed by erode, dilate, erode.
// ----------------------------------------------------------------------------
// Takes one pixel pair per clock while ready and gives one mask pixel per
// clock in raster order while the output is ready. A result leaves L*(W+1)
// items after its pixel, L = 2*erode + dilate; once its completing beat is
// accepted, it passes the memory read and column/row reduce registers of all
// three stages and the result queue write. Flush beats drain the last rows of
// a frame. Each stage does one read and one write of its column history
// memory per item. Input is held off while eight items sit in the pipeline
// and the 8-entry result queue together; with the output always ready at
// most seven are there, so beats can follow back to back. Frame shape and
// radii are taken on the first pixel of a frame; thresholds apply at once.
`default_nettype none

module hsv_foreground_mask_with_morphology (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hsvfg_in_if.sink   in_i,
  hsvfg_out_if.source out_o,
  hsvfg_cfg_if.sink  cfg_i
);
  import hsvfg_pkg::*;

  logic [7:0]       hue_thr_q, sat_thr_q, val_thr_q;
  logic [RAD_W-1:0] erode_rad_q, dilate_rad_q;
  logic [DIM_W-1:0] img_w_q, img_h_q;

  logic             open_q;
  logic [DIM_W-1:0] fw_q, fh_q;
  logic [RAD_W-1:0] fre_q, frd_q;
  logic [DIM_W-1:0] clamp_w, clamp_h, eff_w, eff_h;
  logic [RAD_W-1:0] eff_re, eff_rd;
  logic [RAD_W-1:0] rad [NUM_STAGES];

  logic [COL_W-1:0] pcol_q [NUM_STAGES];
  logic [ROW_W-1:0] prow_q [NUM_STAGES];
  logic [COL_W-1:0] ocol_q [NUM_STAGES];
  logic [ROW_W-1:0] orow_q [NUM_STAGES];

  logic             run   [NUM_STAGES];
  logic             pastd [NUM_STAGES];
  stg_ctl_t         ctl   [NUM_STAGES];
  logic [K_W-1:0]   twor  [NUM_STAGES];
  logic [SUM_W-1:0] csum  [NUM_STAGES];

  logic             in_acc, ignore, adv, in_frame, b0, frame_end, last_pix;
  logic [7:0]       dh, ds, dv;

  tag_t             tag_q [PIPE_DEPTH];
  tag_t             tag_new;
  logic             has1, bit1, has2, bit2, has3, bit3;

  res_t             fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] count_q, inflight_q;
  logic             push, pop;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_thr_q    <= 8'd10;
      sat_thr_q    <= 8'd20;
      val_thr_q    <= 8'd50;
      erode_rad_q  <= RAD_W'(1);
      dilate_rad_q <= RAD_W'(3);
      img_w_q      <= DIM_W'(640);
      img_h_q      <= DIM_W'(480);
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_HUE_THR:    hue_thr_q    <= cfg_i.data[7:0];
        REG_SAT_THR:    sat_thr_q    <= cfg_i.data[7:0];
        REG_VAL_THR:    val_thr_q    <= cfg_i.data[7:0];
        REG_ERODE_RAD:  erode_rad_q  <= cfg_i.data[RAD_W-1:0];
        REG_DILATE_RAD: dilate_rad_q <= cfg_i.data[RAD_W-1:0];
        REG_IMG_WIDTH:  img_w_q      <= cfg_i.data[DIM_W-1:0];
        REG_IMG_HEIGHT: img_h_q      <= cfg_i.data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  always_comb begin
    if (img_w_q < DIM_W'(MIN_DIM)) begin
      clamp_w = DIM_W'(MIN_DIM);
    end else if (img_w_q > DIM_W'(MAX_WIDTH)) begin
      clamp_w = DIM_W'(MAX_WIDTH);
    end else begin
      clamp_w = img_w_q;
    end
    if (img_h_q < DIM_W'(MIN_DIM)) begin
      clamp_h = DIM_W'(MIN_DIM);
    end else if (img_h_q > DIM_W'(MAX_HEIGHT)) begin
      clamp_h = DIM_W'(MAX_HEIGHT);
    end else begin
      clamp_h = img_h_q;
    end
    eff_w  = open_q ? fw_q  : clamp_w;
    eff_h  = open_q ? fh_q  : clamp_h;
    eff_re = open_q ? fre_q : erode_rad_q;
    eff_rd = open_q ? frd_q : dilate_rad_q;
    rad[0] = eff_re;
    rad[1] = eff_rd;
    rad[2] = eff_re;
  end

  // threshold
  always_comb begin
    dh = (in_i.pixel_hue > in_i.back_hue) ? in_i.pixel_hue - in_i.back_hue
                                          : in_i.back_hue - in_i.pixel_hue;
    ds = (in_i.pixel_sat > in_i.back_sat) ? in_i.pixel_sat - in_i.back_sat
                                          : in_i.back_sat - in_i.pixel_sat;
    dv = (in_i.pixel_val > in_i.back_val) ? in_i.pixel_val - in_i.back_val
                                          : in_i.back_val - in_i.pixel_val;
    in_frame = prow_q[0] < ROW_W'(eff_h);
    b0       = in_frame ? (((dh > hue_thr_q) && (ds > sat_thr_q)) || (dv > val_thr_q))
                        : 1'b1;
    in_acc   = in_i.valid && in_i.ready;
    ignore   = (in_i.op == OP_FLUSH) && in_frame;
    adv      = in_acc && !ignore;
  end

  // per-stage position control
  always_comb begin
    for (int s = 0; s < NUM_STAGES; s++) begin
      run[s]   = (s == 0) ? 1'b1 : pastd[(s == 0) ? 0 : s - 1];
      pastd[s] = run[s] && ((prow_q[s] > ROW_W'(rad[s])) ||
                 ((prow_q[s] == ROW_W'(rad[s])) && (pcol_q[s] >= COL_W'(rad[s]))));
      twor[s]  = {1'b0, rad[s]} << 1;
      csum[s]  = SUM_W'(ocol_q[s]) + SUM_W'(rad[s]);
      ctl[s].run  = run[s];
      ctl[s].x    = pcol_q[s];
      ctl[s].k    = (prow_q[s] >= ROW_W'(twor[s])) ? twor[s] : prow_q[s][K_W-1:0];
      ctl[s].emit = pastd[s] && (orow_q[s] < ROW_W'(eff_h));
      for (int j = 0; j < WIN_W; j++) begin
        ctl[s].mm[j] = (K_W'(j) <= twor[s]) && (csum[s] >= SUM_W'(j)) &&
                       ((csum[s] - SUM_W'(j)) < SUM_W'(eff_w));
      end
    end
    last_pix  = (SUM_W'(ocol_q[2]) == SUM_W'(eff_w) - SUM_W'(1)) &&
                (orow_q[2] == ROW_W'(eff_h) - ROW_W'(1));
    frame_end = adv && ctl[2].emit && last_pix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      fw_q   <= DIM_W'(640);
      fh_q   <= DIM_W'(480);
      fre_q  <= RAD_W'(1);
      frd_q  <= RAD_W'(3);
      for (int s = 0; s < NUM_STAGES; s++) begin
        pcol_q[s] <= '0;
        prow_q[s] <= '0;
        ocol_q[s] <= '0;
        orow_q[s] <= '0;
      end
    end else if (frame_end) begin
      open_q <= 1'b0;
      for (int s = 0; s < NUM_STAGES; s++) begin
        pcol_q[s] <= '0;
        prow_q[s] <= '0;
        ocol_q[s] <= '0;
        orow_q[s] <= '0;
      end
    end else if (adv) begin
      if (!open_q) begin
        open_q <= 1'b1;
        fw_q   <= clamp_w;
        fh_q   <= clamp_h;
        fre_q  <= erode_rad_q;
        frd_q  <= dilate_rad_q;
      end
      for (int s = 0; s < NUM_STAGES; s++) begin
        if (run[s]) begin
          if (DIM_W'(pcol_q[s]) == eff_w - DIM_W'(1)) begin
            pcol_q[s] <= '0;
            prow_q[s] <= prow_q[s] + ROW_W'(1);
          end else begin
            pcol_q[s] <= pcol_q[s] + COL_W'(1);
          end
        end
        if (ctl[s].emit) begin
          if (DIM_W'(ocol_q[s]) == eff_w - DIM_W'(1)) begin
            ocol_q[s] <= '0;
            orow_q[s] <= orow_q[s] + ROW_W'(1);
          end else begin
            ocol_q[s] <= ocol_q[s] + COL_W'(1);
          end
        end
      end
    end
  end

  // item tags travel alongside the stages
  always_comb begin
    tag_new.valid = adv;
    tag_new.ctl2  = ctl[1];
    tag_new.ctl3  = ctl[2];
    tag_new.col   = OUT_W'(ocol_q[2]);
    tag_new.row   = orow_q[2][OUT_W-1:0];
    tag_new.last  = last_pix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        tag_q[i] <= '0;
      end
    end else begin
      tag_q[0] <= tag_new;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  hsvfg_stage u_erode1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .dil_i   (1'b0),
    .valid_i (adv),
    .ctl_i   (ctl[0]),
    .bin_i   (b0),
    .has_o   (has1),
    .bit_o   (bit1)
  );

  hsvfg_stage u_dilate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .dil_i   (1'b1),
    .valid_i (tag_q[1].valid),
    .ctl_i   (tag_q[1].ctl2),
    .bin_i   (has1 && bit1),
    .has_o   (has2),
    .bit_o   (bit2)
  );

  hsvfg_stage u_erode2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .dil_i   (1'b0),
    .valid_i (tag_q[3].valid),
    .ctl_i   (tag_q[3].ctl3),
    .bin_i   (!has2 || bit2),
    .has_o   (has3),
    .bit_o   (bit3)
  );

  // result queue
  assign push = tag_q[PIPE_DEPTH-1].valid && has3;
  assign pop  = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= '{mask: bit3, col: tag_q[PIPE_DEPTH-1].col,
                          row: tag_q[PIPE_DEPTH-1].row, last: tag_q[PIPE_DEPTH-1].last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q     <= '0;
      rptr_q     <= '0;
      count_q    <= '0;
      inflight_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + PTR_W'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + PTR_W'(1);
      end
      count_q    <= count_q + CNT_W'(push) - CNT_W'(pop);
      inflight_q <= inflight_q + CNT_W'(adv) - CNT_W'(tag_q[PIPE_DEPTH-1].valid);
    end
  end

  assign in_i.ready       = (inflight_q + count_q) < CNT_W'(FIFO_DEPTH);
  assign out_o.valid      = count_q != '0;
  assign out_o.mask       = fifo_q[rptr_q].mask;
  assign out_o.out_col    = fifo_q[rptr_q].col;
  assign out_o.out_row    = fifo_q[rptr_q].row;
  assign out_o.frame_last = fifo_q[rptr_q].last;

endmodule

`default_nettype wire

// ----- hdl/hsvfg_checker.sv -----
// ----------------------------------------------------------------------------
// hsvfg_checker
// Port-level checks on the mask result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvfg_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       out_mask_i,
  input wire logic [9:0] out_col_i,
  input wire logic [9:0] out_row_i,
  input wire logic       out_last_i
);

  logic out_acc;
  assign out_acc = out_valid_i && out_ready_i;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({out_mask_i, out_col_i, out_row_i, out_last_i}))
    else $error("result beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result beat during reset");

  a_raster: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc ##1 out_acc |-> $past(out_last_i) || (out_col_i == '0) ||
      (out_col_i == $past(out_col_i) + 10'd1))
    else $error("result columns out of raster order");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc ##1 out_acc |-> !$past(out_last_i) ||
      ((out_col_i == '0) && (out_row_i == '0)))
    else $error("frame did not restart at origin");

endmodule

bind hsv_foreground_mask_with_morphology hsvfg_checker u_hsvfg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_mask_i  (out_o.mask),
  .out_col_i   (out_o.out_col),
  .out_row_i   (out_o.out_row),
  .out_last_i  (out_o.frame_last)
);

`default_nettype wire
